// ===== design/iest_pkg.sv =====
// iest_pkg: shared types and constants for the image extrema statistics block
// no dependencies; used by the channel interfaces and the top level

package iest_pkg;

	localparam int PIX_W   = 8;
	localparam int SUM_W   = 10;
	localparam int POS_W   = 12;
	localparam int WIDTH_W = 13;
	localparam int KIND_W  = 3;
	localparam int NUM_KINDS = 8;

	// result kinds in emission order
	typedef enum logic [KIND_W-1:0] {
		KIND_MAX_PIX = 3'd0,
		KIND_MIN_PIX = 3'd1,
		KIND_MAX_R   = 3'd2,
		KIND_MAX_G   = 3'd3,
		KIND_MAX_B   = 3'd4,
		KIND_MIN_R   = 3'd5,
		KIND_MIN_G   = 3'd6,
		KIND_MIN_B   = 3'd7
	} stat_kind_t;

	// packed pixel, red in the low byte
	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	// position of an extreme, low bits of column and row
	typedef struct packed {
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] x;
	} pos_t;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;

endpackage

// ===== design/iest_channels.sv =====
// iest_channels: valid/ready channel interfaces for pixels, results and configuration
// depends on iest_pkg for field widths

interface iest_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [iest_pkg::PIX_W-1:0] red;
	logic [iest_pkg::PIX_W-1:0] green;
	logic [iest_pkg::PIX_W-1:0] blue;
	logic                      last_pixel;

	modport source (output valid, red, green, blue, last_pixel, input ready);
	modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface iest_stat_if;
	logic                       valid;
	logic                       ready;
	logic [iest_pkg::KIND_W-1:0] stat_kind;
	logic [iest_pkg::POS_W-1:0]  x_pos;
	logic [iest_pkg::POS_W-1:0]  y_pos;
	logic [iest_pkg::PIX_W-1:0]  pix_red;
	logic [iest_pkg::PIX_W-1:0]  pix_green;
	logic [iest_pkg::PIX_W-1:0]  pix_blue;
	logic [iest_pkg::PIX_W-1:0]  channel_value;
	logic                       last_result;

	modport source (output valid, stat_kind, x_pos, y_pos, pix_red, pix_green, pix_blue,
		channel_value, last_result, input ready);
	modport sink (input valid, stat_kind, x_pos, y_pos, pix_red, pix_green, pix_blue,
		channel_value, last_result, output ready);
endinterface

interface iest_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [iest_pkg::WIDTH_W-1:0] image_width;

	modport source (output valid, image_width, input ready);
	modport sink (input valid, image_width, output ready);
endinterface

// ===== design/image_extrema_statistics.sv =====
// image_extrema_statistics: per-image min/max tracker for a raster RGB pixel stream
// depends on iest_pkg and the channel interfaces in iest_channels.sv
// first result: valid after the last pixel leaves the input stage and is snapped to the bank
// throughput: one pixel per cycle; the eight results of an image leave a snapshot bank one
//   per cycle while stat_out.ready is high, so a last pixel waits only while the previous
//   image's results are still draining (images under eight pixels, or a stalled result side)
// reset: arst_n clears counters and handshake state at once, width returns to 640

module image_extrema_statistics #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	iest_pixel_if.sink        pixel_in,
	iest_stat_if.source       stat_out,
	iest_cfg_if.sink          cfg
);
	import iest_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
	localparam int ROWX_W = (ROW_W > POS_W) ? ROW_W : POS_W;
	localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_HEIGHT - 1);

	// control state
	logic [WIDTH_W-1:0] width_q;
	logic               s1_valid_s1;
	logic               first_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               busy_q;
	logic [KIND_W-1:0]  cnt_q;

	// input stage payload
	rgb_t               pix_s1;
	logic               last_s1;

	// trackers
	logic [SUM_W-1:0]   sum_max_q, sum_min_q;
	rgb_t               rgb_max_q, rgb_min_q;
	logic [PIX_W-1:0]   ch_q [6];
	pos_t               pos_q [NUM_KINDS];

	// result bank
	rgb_t               bank_rgb_q [2];
	logic [PIX_W-1:0]   bank_ch_q [6];
	pos_t               bank_pos_q [NUM_KINDS];

	// next tracker values
	logic [SUM_W-1:0]   sum_max_n, sum_min_n;
	rgb_t               rgb_max_n, rgb_min_n;
	logic [PIX_W-1:0]   ch_n [6];
	pos_t               pos_n [NUM_KINDS];

	logic [SUM_W-1:0]   sum;
	logic [PIX_W-1:0]   chan [3];
	pos_t               pos_cur;
	logic [CMP_W-1:0]   col_ext, col_next, eff_width;
	logic [ROWX_W-1:0]  row_ext;
	logic               wrap;
	logic               drain_done, s1_adv, snap;

	// handshake
	assign drain_done = busy_q && stat_out.ready && (cnt_q == KIND_MIN_B);
	assign s1_adv = s1_valid_s1 && (!last_s1 || !busy_q || drain_done);
	assign snap = s1_adv && last_s1;
	assign pixel_in.ready = !s1_valid_s1 || s1_adv;
	assign cfg.ready = 1'b1;

	// position and column wrap
	always_comb begin
		col_ext = CMP_W'(col_q);
		row_ext = ROWX_W'(row_q);
		pos_cur.x = col_ext[POS_W-1:0];
		pos_cur.y = row_ext[POS_W-1:0];
		col_next = col_ext + CMP_W'(1);
		if (width_q == '0) begin
			eff_width = CMP_W'(1);
		end else if (CMP_W'(width_q) > MAX_W_C) begin
			eff_width = MAX_W_C;
		end else begin
			eff_width = CMP_W'(width_q);
		end
		wrap = (col_next >= eff_width);
	end

	// tracker update for the pixel in the input stage
	always_comb begin
		sum = SUM_W'(pix_s1.red) + SUM_W'(pix_s1.green) + SUM_W'(pix_s1.blue);
		chan[0] = pix_s1.red;
		chan[1] = pix_s1.green;
		chan[2] = pix_s1.blue;
		sum_max_n = sum_max_q;
		sum_min_n = sum_min_q;
		rgb_max_n = rgb_max_q;
		rgb_min_n = rgb_min_q;
		ch_n = ch_q;
		pos_n = pos_q;
		if (first_q) begin
			sum_max_n = sum;
			sum_min_n = sum;
			rgb_max_n = pix_s1;
			rgb_min_n = pix_s1;
			for (int k = 0; k < 3; k++) begin
				ch_n[k] = chan[k];
				ch_n[k+3] = chan[k];
			end
			for (int k = 0; k < NUM_KINDS; k++) begin
				pos_n[k] = pos_cur;
			end
		end else begin
			if (sum > sum_max_q) begin
				sum_max_n = sum;
				rgb_max_n = pix_s1;
				pos_n[KIND_MAX_PIX] = pos_cur;
			end
			if (sum < sum_min_q) begin
				sum_min_n = sum;
				rgb_min_n = pix_s1;
				pos_n[KIND_MIN_PIX] = pos_cur;
			end
			for (int k = 0; k < 3; k++) begin
				if (chan[k] > ch_q[k]) begin
					ch_n[k] = chan[k];
					pos_n[k+2] = pos_cur;
				end
				if (chan[k] < ch_q[k+3]) begin
					ch_n[k+3] = chan[k];
					pos_n[k+5] = pos_cur;
				end
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			s1_valid_s1 <= 1'b0;
			first_q <= 1'b1;
			col_q <= '0;
			row_q <= '0;
			busy_q <= 1'b0;
			cnt_q <= KIND_MAX_PIX;
		end else begin
			if (cfg.valid) begin
				width_q <= cfg.image_width;
			end
			if (pixel_in.ready) begin
				s1_valid_s1 <= pixel_in.valid;
			end
			if (s1_adv) begin
				if (last_s1) begin
					first_q <= 1'b1;
					col_q <= '0;
					row_q <= '0;
				end else begin
					first_q <= 1'b0;
					if (wrap) begin
						col_q <= '0;
						if (row_q < ROW_LIMIT) begin
							row_q <= row_q + ROW_W'(1);
						end
					end else begin
						col_q <= col_next[COL_W-1:0];
					end
				end
			end
			// result drain counter
			if (snap) begin
				busy_q <= 1'b1;
				cnt_q <= KIND_MAX_PIX;
			end else if (drain_done) begin
				busy_q <= 1'b0;
			end else if (busy_q && stat_out.ready) begin
				cnt_q <= cnt_q + KIND_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pixel_in.ready && pixel_in.valid) begin
			pix_s1.red <= pixel_in.red;
			pix_s1.green <= pixel_in.green;
			pix_s1.blue <= pixel_in.blue;
			last_s1 <= pixel_in.last_pixel;
		end
		if (s1_adv) begin
			sum_max_q <= sum_max_n;
			sum_min_q <= sum_min_n;
			rgb_max_q <= rgb_max_n;
			rgb_min_q <= rgb_min_n;
			ch_q <= ch_n;
			pos_q <= pos_n;
		end
		if (snap) begin
			bank_rgb_q[0] <= rgb_max_n;
			bank_rgb_q[1] <= rgb_min_n;
			bank_ch_q <= ch_n;
			bank_pos_q <= pos_n;
		end
	end

	// result selection from the bank
	always_comb begin
		stat_out.valid = busy_q;
		stat_out.stat_kind = cnt_q;
		stat_out.x_pos = bank_pos_q[cnt_q].x;
		stat_out.y_pos = bank_pos_q[cnt_q].y;
		stat_out.last_result = (cnt_q == KIND_MIN_B);
		stat_out.pix_red = '0;
		stat_out.pix_green = '0;
		stat_out.pix_blue = '0;
		stat_out.channel_value = '0;
		case (stat_kind_t'(cnt_q))
			KIND_MAX_PIX: begin
				stat_out.pix_red = bank_rgb_q[0].red;
				stat_out.pix_green = bank_rgb_q[0].green;
				stat_out.pix_blue = bank_rgb_q[0].blue;
			end
			KIND_MIN_PIX: begin
				stat_out.pix_red = bank_rgb_q[1].red;
				stat_out.pix_green = bank_rgb_q[1].green;
				stat_out.pix_blue = bank_rgb_q[1].blue;
			end
			KIND_MAX_R: stat_out.channel_value = bank_ch_q[0];
			KIND_MAX_G: stat_out.channel_value = bank_ch_q[1];
			KIND_MAX_B: stat_out.channel_value = bank_ch_q[2];
			KIND_MIN_R: stat_out.channel_value = bank_ch_q[3];
			KIND_MIN_G: stat_out.channel_value = bank_ch_q[4];
			KIND_MIN_B: stat_out.channel_value = bank_ch_q[5];
			default: stat_out.channel_value = '0;
		endcase
	end

	// a snapshot always starts the drain at the first kind
	a_snap_starts: assert property (@(posedge clk) disable iff (!arst_n)
		snap |=> busy_q && (cnt_q == KIND_MAX_PIX))
		else $error("snapshot did not restart the result drain");

	// the drain ends after the eighth transfer unless a new snapshot arrives
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done && !snap |=> !busy_q)
		else $error("result drain did not end after the final kind");

	// a last pixel never overwrites a bank that is still draining
	a_bank_safe: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !drain_done |-> !snap)
		else $error("bank overwritten during drain");

	// once loaded, the minimum sum never exceeds the maximum
	a_sum_order: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |-> (sum_min_q <= sum_max_q))
		else $error("tracked minimum sum above maximum");

	// once loaded, each channel minimum never exceeds its maximum
	a_chan_order: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |-> (ch_q[3] <= ch_q[0]) && (ch_q[4] <= ch_q[1]) && (ch_q[5] <= ch_q[2]))
		else $error("tracked channel minimum above maximum");

endmodule
